@@ rtl/bcd_pkg.sv @@
// Shared types and constants of the binary cross dilation unit.
// Used by the top level; no dependencies of its own.
package bcd_pkg;

	localparam int PIXEL_W     = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 11;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

	// Register values after reset
	localparam int RADIUS_RESET       = 2;
	localparam int FRAME_WIDTH_RESET  = 1024;
	localparam int FRAME_HEIGHT_RESET = 1024;

	// Only this pixel value counts as set
	localparam logic [PIXEL_W-1:0] SET_VALUE = 8'd1;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               flush;
	} pix_word_t;

	typedef struct packed {
		logic grown_pixel;
		logic frame_end;
	} grow_word_t;

endpackage

@@ rtl/bcd_line_store.sv @@
// Row store of the dilation unit: a ring of one-bit row memories.
// Each row has one write port and two registered read ports; no package needed.
module bcd_line_store #(
	parameter int MAX_WIDTH = 1024,
	parameter int NSLOT     = 7
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [$clog2(NSLOT)-1:0]     wr_slot,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
	input  logic                         wr_bit,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_col_a,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_col_b,
	output logic [NSLOT-1:0]             rd_a_s1,
	output logic [NSLOT-1:0]             rd_b_s1
);

	localparam int SW = $clog2(NSLOT);

	for (genvar g = 0; g < NSLOT; g++) begin : g_slot
		logic slot_mem_q [MAX_WIDTH];
		logic rd_a_bit_s1;
		logic rd_b_bit_s1;

		// Write the current row, read both columns of every row (old data on a clash)
		always_ff @(posedge clk) begin
			if (en) begin
				if (wr_slot == SW'(g)) begin
					slot_mem_q[wr_col] <= wr_bit;
				end
				rd_a_bit_s1 <= slot_mem_q[rd_col_a];
				rd_b_bit_s1 <= slot_mem_q[rd_col_b];
			end
		end

		assign rd_a_s1[g] = rd_a_bit_s1;
		assign rd_b_s1[g] = rd_b_bit_s1;
	end

endmodule

@@ rtl/binary_cross_dilation_unit.sv @@
// Binary dilation with a cross of configurable arm length over a raster pixel stream.
// Depends on bcd_pkg and bcd_line_store.
//
// The unit takes one pixel word per clock and gives at most one result word per clock.
// A pixel counts as set only when it equals 1; a result is 1 when its pixel or any in-frame
// pixel on its row or column within radius is set. The result for frame pixel p leaves with
// the input word of pixel p + radius*frame_width, so the last radius rows come out only
// while the host sends words after the frame, flush words or pixels alike (a flush word
// inside the frame is dropped). A word's result is formed in the evaluation stage, which
// the accepting edge loads together with the registered read of the row store, and then
// moves to the output register. A word is taken in every clock while results are taken;
// a result held by grow_stall stalls the input as soon as the evaluation stage also holds
// a word that produces a result. The row store is a ring of 2*MAX_RADIUS+1 rows of
// MAX_WIDTH bits, read at two columns per clock; it needs no clearing after reset, since
// only bits written earlier in the same frame are looked at. A write to a mapped register
// restarts the frame; a configuration write is meant for an idle unit.
module binary_cross_dilation_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pix_valid,
	output logic                               pix_stall,
	input  bcd_pkg::pix_word_t                 pix_word,
	output logic                               grow_valid,
	input  logic                               grow_stall,
	output bcd_pkg::grow_word_t                grow_word,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [bcd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int NSLOT = 2 * MAX_RADIUS + 1;
	localparam int SW    = $clog2(NSLOT);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
	localparam int KW    = $clog2(MAX_RADIUS + 1);
	localparam int TW    = CW + 1;
	localparam int PW    = ((RW > HW) ? RW : HW) + 1;
	localparam int WINW  = 2 * MAX_RADIUS;
	localparam int RADIUS_INIT = (bcd_pkg::RADIUS_RESET > MAX_RADIUS) ?
		MAX_RADIUS : bcd_pkg::RADIUS_RESET;
	localparam int WIDTH_INIT  = (bcd_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
		MAX_WIDTH : bcd_pkg::FRAME_WIDTH_RESET;
	localparam int HEIGHT_INIT = (bcd_pkg::FRAME_HEIGHT_RESET > MAX_HEIGHT) ?
		MAX_HEIGHT : bcd_pkg::FRAME_HEIGHT_RESET;

	// Ring slot that lies rows_back rows behind slot
	function automatic logic [SW-1:0] slot_back(input logic [SW-1:0] slot, input int rows_back);
		int s;
		s = int'(slot) - rows_back;
		if (s < 0) begin
			s = s + NSLOT;
		end
		return SW'(s);
	endfunction

	// Effective configuration and frame position
	logic [KW-1:0]          radius_q;
	logic [WW-1:0]          width_q;
	logic [HW-1:0]          height_q;
	logic [CW-1:0]          col_q;
	logic [RW-1:0]          row_q;
	logic [SW-1:0]          slot_q;
	logic [WINW-1:0]        window_q;
	logic                   grow_valid_q;
	bcd_pkg::grow_word_t    grow_word_q;

	// Evaluation stage
	logic                   valid_s1;
	logic                   produce_s1;
	logic                   last_s1;
	logic                   bit_s1;
	logic                   self_s1;
	logic [SW-1:0]          slot_s1;
	logic [KW-1:0]          back_s1;
	logic [MAX_RADIUS-1:0]  hl_s1;
	logic [MAX_RADIUS-1:0]  hr_s1;
	logic [MAX_RADIUS-1:0]  vu_s1;
	logic [MAX_RADIUS-1:0]  vd_s1;
	logic [NSLOT-1:0]       rd_a_s1;
	logic [NSLOT-1:0]       rd_b_s1;

	// Intake signals
	logic                   cfg_write;
	logic                   cfg_hit;
	logic                   pix_accept;
	logic                   in_frame;
	logic                   advance;
	logic                   cur_bit;
	logic                   produce;
	logic                   last;
	logic                   col_end;
	logic [PW-1:0]          pr_p;
	logic [MAX_RADIUS-1:0]  hl;
	logic [MAX_RADIUS-1:0]  hr;
	logic [MAX_RADIUS-1:0]  vu;
	logic [MAX_RADIUS-1:0]  vd;
	logic [TW-1:0]          look_t;
	logic [KW-1:0]          look_d;
	logic [CW-1:0]          look_col;
	logic                   look_self;

	// Evaluation signals
	logic                   s1_move;
	logic                   s_bit;
	logic [WINW:0]          window_new;
	logic [WINW:0]          taps;
	logic                   grown;

	assign cfg_ready  = 1'b1;
	assign cfg_write  = cfg_valid && cfg_ready;
	assign cfg_hit    = cfg_write && ((cfg_index == bcd_pkg::CFG_RADIUS) ||
		(cfg_index == bcd_pkg::CFG_FRAME_WIDTH) || (cfg_index == bcd_pkg::CFG_FRAME_HEIGHT));

	assign pix_accept = pix_valid && !pix_stall;
	assign s1_move    = valid_s1 && (!produce_s1 || !grow_valid_q || !grow_stall);
	assign pix_stall  = valid_s1 && !s1_move;

	// Classify the incoming word and derive bounds for its output pixel
	always_comb begin
		logic [PW-1:0] row_p;
		logic [PW-1:0] h_p;
		logic [PW-1:0] r_p;
		row_p    = PW'(row_q);
		h_p      = PW'(height_q);
		r_p      = PW'(radius_q);
		in_frame = row_p < h_p;
		advance  = pix_accept && !(in_frame && pix_word.flush);
		cur_bit  = in_frame && (pix_word.pixel == bcd_pkg::SET_VALUE);
		produce  = (row_p >= r_p) && ((row_p - r_p) < h_p);
		pr_p     = row_p - r_p;
		col_end  = (col_q == CW'(width_q - WW'(1)));
		last     = produce && (pr_p == (h_p - PW'(1))) && col_end;
		for (int k = 1; k <= MAX_RADIUS; k++) begin
			hl[k-1] = (k <= int'(radius_q)) && (TW'(col_q) >= TW'(k));
			hr[k-1] = (k <= int'(radius_q)) && ((TW'(col_q) + TW'(k)) < TW'(width_q));
			vu[k-1] = (k <= int'(radius_q)) && (pr_p >= PW'(k));
			vd[k-1] = (k <= int'(radius_q)) && ((pr_p + PW'(k)) < h_p);
		end
	end

	// Locate the pixel radius steps ahead of the output pixel: column and rows forward
	always_comb begin
		look_t = TW'(col_q) + TW'(radius_q);
		look_d = '0;
		for (int i = 0; i < MAX_RADIUS; i++) begin
			if (look_t >= TW'(width_q)) begin
				look_t = look_t - TW'(width_q);
				look_d = look_d + KW'(1);
			end
		end
		look_col  = CW'(look_t);
		look_self = (look_d == radius_q) && (look_col == col_q);
	end

	// Configuration registers, stored already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= KW'(RADIUS_INIT);
			width_q  <= WW'(WIDTH_INIT);
			height_q <= HW'(HEIGHT_INIT);
		end else if (cfg_write) begin
			unique case (cfg_index)
				bcd_pkg::CFG_RADIUS: begin
					if (int'(cfg_data[1:0]) > MAX_RADIUS) begin
						radius_q <= KW'(MAX_RADIUS);
					end else begin
						radius_q <= KW'(cfg_data[1:0]);
					end
				end
				bcd_pkg::CFG_FRAME_WIDTH: begin
					if (cfg_data == '0) begin
						width_q <= WW'(1);
					end else if (int'(cfg_data) > MAX_WIDTH) begin
						width_q <= WW'(MAX_WIDTH);
					end else begin
						width_q <= WW'(cfg_data);
					end
				end
				bcd_pkg::CFG_FRAME_HEIGHT: begin
					if (cfg_data == '0) begin
						height_q <= HW'(1);
					end else if (int'(cfg_data) > MAX_HEIGHT) begin
						height_q <= HW'(MAX_HEIGHT);
					end else begin
						height_q <= HW'(cfg_data);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Advance the frame position; restart on a mapped register write or after the last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_end) begin
				col_q  <= '0;
				slot_q <= (slot_q == SW'(NSLOT - 1)) ? '0 : slot_q + SW'(1);
				row_q  <= last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	bcd_line_store #(
		.MAX_WIDTH (MAX_WIDTH),
		.NSLOT     (NSLOT)
	) u_line_store (
		.clk      (clk),
		.en       (advance),
		.wr_slot  (slot_q),
		.wr_col   (col_q),
		.wr_bit   (cur_bit),
		.rd_col_a (col_q),
		.rd_col_b (look_col),
		.rd_a_s1  (rd_a_s1),
		.rd_b_s1  (rd_b_s1)
	);

	// Evaluation stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the word's flags next to the row store read data
	always_ff @(posedge clk) begin
		if (advance) begin
			produce_s1 <= produce;
			last_s1    <= last;
			bit_s1     <= cur_bit;
			self_s1    <= look_self;
			slot_s1    <= slot_q;
			back_s1    <= radius_q - look_d;
			hl_s1      <= hl;
			hr_s1      <= hr;
			vu_s1      <= vu;
			vd_s1      <= vd;
		end
	end

	// Column taps: tap j is the pixel j rows above the incoming one
	always_comb begin
		taps[0] = bit_s1;
		for (int j = 1; j <= WINW; j++) begin
			taps[j] = rd_a_s1[slot_back(slot_s1, j)];
		end
	end

	// Row window: entry i is the pixel radius-i places after the output pixel
	always_comb begin
		s_bit      = self_s1 ? bit_s1 : rd_b_s1[slot_back(slot_s1, int'(back_s1))];
		window_new = {window_q, s_bit};
		grown      = window_new[radius_q];
		for (int k = 1; k <= MAX_RADIUS; k++) begin
			if (k <= int'(radius_q)) begin
				grown = grown
					| (hl_s1[k-1] & window_new[int'(radius_q) + k])
					| (hr_s1[k-1] & window_new[int'(radius_q) - k])
					| (vu_s1[k-1] & taps[int'(radius_q) + k])
					| (vd_s1[k-1] & taps[int'(radius_q) - k]);
			end
		end
	end

	// Shift the row window once per word leaving the evaluation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (s1_move) begin
			window_q <= window_new[WINW-1:0];
		end
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grow_valid_q <= 1'b0;
		end else if (s1_move && produce_s1) begin
			grow_valid_q <= 1'b1;
		end else if (!grow_stall) begin
			grow_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && produce_s1) begin
			grow_word_q.grown_pixel <= grown;
			grow_word_q.frame_end   <= last_s1;
		end
	end

	assign grow_valid = grow_valid_q;
	assign grow_word  = grow_word_q;

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> valid_s1)
		else $error("input stalled with an empty evaluation stage");

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) < width_q)
		else $error("column position beyond frame width");

	a_last_produces: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 |-> produce_s1)
		else $error("frame end flagged on a word without a result");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SW'(NSLOT - 1))
		else $error("row ring slot out of range");

endmodule

@@ bench/binary_cross_dilation_unit_tb.sv @@
// Self-checking bench for binary_cross_dilation_unit: random raster frames with flush tails.
// Depends on bcd_pkg and the unit itself; results are checked against an in-bench predictor.
`timescale 1ns / 1ps

module binary_cross_dilation_unit_tb;

	localparam int LINE_W       = 1024;
	localparam int FRAME_H_MAX  = 1024;
	localparam int ARM_MAX      = 3;
	localparam int STORE_DEPTH  = 2 * ARM_MAX * LINE_W;
	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 12;
	localparam int DRAIN_CYCLES = 8;
	localparam int END_CYCLES   = 20;
	localparam int LONG_HOLD    = 200;
	localparam int RANDOM_ITEMS = 800;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int REPORT_MAX   = 10;

	// Unmapped register index; a write there is ignored and keeps the frame position
	localparam logic [bcd_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	bcd_pkg::pix_word_t pix_word = '0;
	logic grow_valid;
	logic grow_stall = 1'b0;
	bcd_pkg::grow_word_t grow_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bcd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [bcd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	binary_cross_dilation_unit #(
		.MAX_WIDTH(LINE_W),
		.MAX_HEIGHT(FRAME_H_MAX),
		.MAX_RADIUS(ARM_MAX)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix_word(pix_word),
		.grow_valid(grow_valid),
		.grow_stall(grow_stall),
		.grow_word(grow_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Words waiting to be sent, and grown pixels waiting to come out
	bcd_pkg::pix_word_t pix_send_q[$];
	bcd_pkg::grow_word_t grow_expect_q[$];

	// Handshake flags captured at the rising edge, read at the falling edge
	bit pix_taken = 1'b0;
	bit cfg_took = 1'b0;

	// Traffic shaping controls set by the stimulus
	bit no_idle = 1'b0;
	bit sender_pause = 1'b0;
	bit long_hold_go = 1'b0;

	int unsigned fail_count = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;

	// Predictor state: register copies, frame position and stored set bits
	logic [1:0] reg_radius = 2'(bcd_pkg::RADIUS_RESET);
	logic [bcd_pkg::CFG_DATA_W-1:0] reg_width = bcd_pkg::CFG_DATA_W'(bcd_pkg::FRAME_WIDTH_RESET);
	logic [bcd_pkg::CFG_DATA_W-1:0] reg_height =
		bcd_pkg::CFG_DATA_W'(bcd_pkg::FRAME_HEIGHT_RESET);
	int unsigned col_in = 0;
	int unsigned row_in = 0;
	int unsigned out_idx = 0;
	bit line_bits[STORE_DEPTH];

	function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned top);
		if (raw == 0) return 1;
		if (raw > top) return top;
		return raw;
	endfunction

	function automatic void restart_frame_pos();
		col_in = 0;
		row_in = 0;
		out_idx = 0;
	endfunction

	function automatic void apply_reg(input logic [bcd_pkg::CFG_INDEX_W-1:0] idx,
			input logic [bcd_pkg::CFG_DATA_W-1:0] val);
		unique case (idx)
			bcd_pkg::CFG_RADIUS: begin
				reg_radius = val[1:0];
				restart_frame_pos();
			end
			bcd_pkg::CFG_FRAME_WIDTH: begin
				reg_width = val;
				restart_frame_pos();
			end
			bcd_pkg::CFG_FRAME_HEIGHT: begin
				reg_height = val;
				restart_frame_pos();
			end
			default: ;
		endcase
	endfunction

	// Set bit at frame index q; index cur is the word arriving now
	function automatic bit set_bit_at(input int unsigned q, input int unsigned cur,
			input bit cur_bit);
		if (q == cur) return cur_bit;
		return line_bits[q % STORE_DEPTH];
	endfunction

	// Advance the frame by one accepted word; return 1 when a grown pixel leaves
	function automatic bit dilate_predict(input bcd_pkg::pix_word_t wd,
			output bcd_pkg::grow_word_t res);
		int unsigned w, h, r, total, lag, n, p, pr, pc;
		bit cur, g, last, made;
		w = clamp_dim(reg_width, LINE_W);
		h = clamp_dim(reg_height, FRAME_H_MAX);
		r = (reg_radius > ARM_MAX) ? ARM_MAX : reg_radius;
		total = w * h;
		lag = r * w;
		n = row_in * w + col_in;
		cur = 1'b0;
		last = 1'b0;
		made = 1'b0;
		res = '0;
		// Drop a flush word that arrives inside the frame
		if (n < total) begin
			if (wd.flush) return 1'b0;
			cur = (wd.pixel == bcd_pkg::SET_VALUE);
		end
		if (n >= lag && out_idx < total) begin
			p = out_idx;
			pr = p / w;
			pc = p % w;
			g = set_bit_at(p, n, cur);
			for (int unsigned k = 1; k <= r; k++) begin
				if (pc >= k) g |= set_bit_at(p - k, n, cur);
				if (pc + k < w) g |= set_bit_at(p + k, n, cur);
				if (pr >= k) g |= set_bit_at(p - k * w, n, cur);
				if (pr + k < h) g |= set_bit_at(p + k * w, n, cur);
			end
			last = (p == total - 1);
			res.grown_pixel = g;
			res.frame_end = last;
			out_idx = p + 1;
			made = 1'b1;
		end
		if (n < total) line_bits[n % STORE_DEPTH] = cur;
		col_in++;
		if (col_in >= w) begin
			col_in = 0;
			row_in++;
		end
		if (last) restart_frame_pos();
		return made;
	endfunction

	// Idle length: mostly short, a few long
	function automatic int unsigned idle_len();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 85) return $urandom_range(1, 3);
		if (sel < 97) return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	// Sample both channels and the register port at the rising edge
	always @(posedge clk) begin : monitor
		bcd_pkg::grow_word_t want;
		bit made;
		pix_taken = 1'b0;
		cfg_took = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				cfg_took = 1'b1;
				apply_reg(cfg_index, cfg_data);
			end
			if (grow_valid && !grow_stall) begin
				results_seen++;
				if (grow_expect_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("result %0d: unexpected word grown_pixel=%0b frame_end=%0b",
							results_seen, grow_word.grown_pixel, grow_word.frame_end);
				end else begin
					want = grow_expect_q.pop_front();
					if (grow_word.grown_pixel !== want.grown_pixel ||
							grow_word.frame_end !== want.frame_end) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display("result %0d: want grown_pixel=%0b frame_end=%0b, got %0b %0b",
								results_seen, want.grown_pixel, want.frame_end,
								grow_word.grown_pixel, grow_word.frame_end);
					end
				end
			end
			if (pix_valid && !pix_stall) begin
				pix_taken = 1'b1;
				made = dilate_predict(pix_word, want);
				if (made) grow_expect_q = {grow_expect_q, want};
			end
		end
	end

	// Send pending pixel words; hold a word until it is taken, then maybe idle
	int unsigned send_gap = 0;
	always @(negedge clk) begin : pix_driver
		if (arst_n && !(pix_valid && !pix_taken)) begin
			if (send_gap != 0) begin
				send_gap--;
				pix_valid <= 1'b0;
			end else if (!sender_pause && pix_send_q.size() != 0) begin
				pix_word <= pix_send_q.pop_front();
				pix_valid <= 1'b1;
				if (!no_idle && $urandom_range(0, 2) == 0) send_gap = idle_len();
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// Stall the result side at random, plus one long hold on request
	int unsigned stall_left = 0;
	int unsigned long_hold_left = 0;
	bit long_hold_seen = 1'b0;
	always @(negedge clk) begin : grow_receiver
		if (long_hold_go && !long_hold_seen) begin
			long_hold_seen = 1'b1;
			long_hold_left = LONG_HOLD;
		end
		if (long_hold_left != 0) begin
			long_hold_left--;
			grow_stall <= 1'b1;
		end else if (no_idle || stall_left == 0) begin
			grow_stall <= 1'b0;
			if (!no_idle && $urandom_range(0, 3) == 0) stall_left = idle_len();
		end else begin
			stall_left--;
			grow_stall <= 1'b1;
		end
	end

	// Bound the run
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** binary_cross_dilation_unit: FAILED **");
			$finish;
		end
	end

	task automatic queue_word(input logic [bcd_pkg::PIXEL_W-1:0] px, input logic fl);
		bcd_pkg::pix_word_t wd;
		wd.pixel = px;
		wd.flush = fl;
		pix_send_q = {pix_send_q, wd};
	endtask

	function automatic logic [bcd_pkg::PIXEL_W-1:0] rand_pixel(input int unsigned density);
		if ($urandom_range(0, 99) < density) return bcd_pkg::SET_VALUE;
		if ($urandom_range(0, 1) == 0) return '0;
		return bcd_pkg::PIXEL_W'($urandom_range(0, 255));
	endfunction

	// Queue one frame and its flush tail, cut off after limit counted words
	task automatic queue_frame(input int unsigned r, input int unsigned w, input int unsigned h,
			input int unsigned limit, inout int unsigned counted);
		int unsigned body, span, density;
		body = w * h;
		span = body + r * w;
		density = $urandom_range(0, 60);
		for (int unsigned i = 0; i < span && i < limit; i++) begin
			if (i < body) begin
				// Stray flush inside the frame is dropped by the unit
				if ($urandom_range(0, 19) == 0)
					queue_word(bcd_pkg::PIXEL_W'($urandom_range(0, 255)), 1'b1);
				queue_word(rand_pixel(density), 1'b0);
			end else if ($urandom_range(0, 9) < 7) begin
				queue_word(bcd_pkg::PIXEL_W'($urandom_range(0, 255)), 1'b1);
			end else begin
				// A pixel past the frame acts as a flush
				queue_word(bcd_pkg::PIXEL_W'($urandom_range(0, 255)), 1'b0);
			end
			counted++;
		end
	endtask

	// Wait until every word is sent and every result has come, then let the pipe settle
	task automatic wait_drained();
		do @(negedge clk);
		while (pix_send_q.size() != 0 || pix_valid || grow_expect_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [bcd_pkg::CFG_INDEX_W-1:0] idx,
			input int unsigned val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= bcd_pkg::CFG_DATA_W'(val);
		cfg_valid <= 1'b1;
		do @(negedge clk);
		while (!cfg_took);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_config(input int unsigned r, input int unsigned w, input int unsigned h);
		wait_drained();
		write_reg(bcd_pkg::CFG_RADIUS, r);
		write_reg(bcd_pkg::CFG_FRAME_WIDTH, w);
		write_reg(bcd_pkg::CFG_FRAME_HEIGHT, h);
	endtask

	initial begin : stimulus
		int unsigned counted, nr, nw, nh, w, h, span, nframes, sel;
		bit need_cfg, wrote;
		int unsigned gen_r, gen_w, gen_h;
		logic [bcd_pkg::PIXEL_W-1:0] first_frame[12];
		counted = 0;
		first_frame = '{8'h01, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h01,
			8'hFE, 8'h7F, 8'h00, 8'h03, 8'h00, 8'h01};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: radius 2 over 1024-wide rows, first outputs after two rows
		no_idle = 1'b1;
		repeat (2060) queue_word(rand_pixel(20), 1'b0);
		wait_drained();
		no_idle = 1'b0;

		// Small frame with assorted pixel values, a stray flush and a mixed tail
		write_config(1, 4, 3);
		for (int i = 0; i < 12; i++) begin
			queue_word(first_frame[i], 1'b0);
			if (i == 2) queue_word(bcd_pkg::SET_VALUE, 1'b1);
		end
		queue_word(8'h00, 1'b1);
		queue_word(bcd_pkg::SET_VALUE, 1'b0);
		queue_word(8'hFF, 1'b1);
		queue_word(8'h55, 1'b0);

		// Radius zero copies the set flag
		write_config(0, 4, 1);
		queue_word(bcd_pkg::SET_VALUE, 1'b0);
		queue_word(8'h02, 1'b0);
		queue_word(bcd_pkg::SET_VALUE, 1'b0);
		queue_word(8'h00, 1'b0);

		// Write to the unmapped index in mid-frame: position must be kept
		write_config(2, 4, 2);
		repeat (3) queue_word(rand_pixel(40), 1'b0);
		wait_drained();
		write_reg(CFG_SPARE, 11'h7FF);
		repeat (5) queue_word(rand_pixel(40), 1'b0);
		repeat (8) queue_word(bcd_pkg::PIXEL_W'($urandom_range(0, 255)), 1'b1);

		// Width not above radius
		write_config(3, 3, 5);
		queue_frame(3, 3, 5, 1 << 30, counted);
		// Zero width and height act as one
		write_config(3, 0, 0);
		queue_frame(3, 1, 1, 1 << 30, counted);
		// Oversized height saturates; long hold on the result side while the sender
		// keeps offering words
		write_config(1, 0, 2047);
		no_idle = 1'b1;
		queue_frame(1, 1, FRAME_H_MAX, 1 << 30, counted);
		long_hold_go = 1'b1;
		wait_drained();
		// Oversized width saturates
		write_config(0, 2047, 1);
		queue_frame(0, LINE_W, 1, 1 << 30, counted);
		wait_drained();
		no_idle = 1'b0;

		// Sender pauses mid-frame until every result has come
		write_config(2, 6, 6);
		queue_frame(2, 6, 6, 1 << 30, counted);
		do @(negedge clk);
		while (pix_send_q.size() > 20);
		sender_pause = 1'b1;
		do @(negedge clk);
		while (pix_valid || grow_expect_q.size() != 0);
		repeat (30) @(negedge clk);
		sender_pause = 1'b0;
		gen_r = 2;
		gen_w = 6;
		gen_h = 6;

		// Random frames under changing settings; some frames are cut short
		counted = 0;
		need_cfg = 1'b1;
		while (counted < RANDOM_ITEMS) begin
			if (need_cfg || $urandom_range(0, 2) == 0) begin
				wait_drained();
				wrote = 1'b0;
				nr = $urandom_range(0, 3);
				sel = $urandom_range(0, 99);
				if (sel < 70) nw = $urandom_range(4, 10);
				else if (sel < 85) nw = $urandom_range(0, 3);
				else if (sel < 97) nw = $urandom_range(11, 40);
				else nw = $urandom_range(41, 100);
				if ($urandom_range(0, 9) < 6) begin
					write_reg(bcd_pkg::CFG_RADIUS, nr);
					gen_r = nr;
					wrote = 1'b1;
				end
				if ($urandom_range(0, 9) < 6) begin
					write_reg(bcd_pkg::CFG_FRAME_WIDTH, nw);
					gen_w = nw;
					wrote = 1'b1;
				end
				if (gen_w > 40) nh = $urandom_range(1, 3);
				else if ($urandom_range(0, 99) < 80) nh = $urandom_range(1, 6);
				else if ($urandom_range(0, 1) == 0) nh = 0;
				else nh = $urandom_range(7, 16);
				if (!wrote || gen_h > 16 || $urandom_range(0, 9) < 6) begin
					write_reg(bcd_pkg::CFG_FRAME_HEIGHT, nh);
					gen_h = nh;
				end
				need_cfg = 1'b0;
			end
			no_idle = ($urandom_range(0, 7) == 0);
			nframes = $urandom_range(1, 3);
			for (int unsigned f = 0; f < nframes; f++) begin
				w = clamp_dim(gen_w, LINE_W);
				h = clamp_dim(gen_h, FRAME_H_MAX);
				span = w * h + gen_r * w;
				if ($urandom_range(0, 9) == 0) begin
					// Broken frame: restart it with a register write
					queue_frame(gen_r, w, h, $urandom_range(0, span - 1), counted);
					need_cfg = 1'b1;
					break;
				end
				queue_frame(gen_r, w, h, span, counted);
			end
		end

		wait_drained();
		no_idle = 1'b0;
		repeat (END_CYCLES) @(negedge clk);
		if (fail_count == 0 && grow_expect_q.size() == 0) begin
			$display("** binary_cross_dilation_unit: PASSED **");
		end else begin
			$display("** binary_cross_dilation_unit: FAILED **");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/bcd_pkg.sv
rtl/bcd_line_store.sv
rtl/binary_cross_dilation_unit.sv
bench/binary_cross_dilation_unit_tb.sv
